/* rtl/olc_pkg.sv */
// Shared types, codes and sizes for the ordered list with cursor.
`default_nettype none

package olc_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 16;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 3;
    localparam int ENTRY_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PREV   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PLAY   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SHOW   = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_AT_END    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    // Contents of one list position.
    typedef struct packed {
        logic             used;
        logic             cur;
        logic [KEY_W-1:0] key;
    } slot_t;

    // Operation token that walks along the row, one position per cycle.
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic             at_head;
        logic             done;
        logic             move;
        logic             blocked;
        logic             del_cur;
        logic             cap_valid;
        logic [KEY_W-1:0] cap_key;
        logic             head_used;
        logic [KEY_W-1:0] head_key;
    } wave_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* rtl/olc_cell.sv */
// One list position: holds an entry and applies the passing operation token.
`default_nettype none

module olc_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wave_valid_in,
    input  wire olc_pkg::wave_t wave_in,
    input  wire olc_pkg::slot_t nb,
    input  wire logic          head_set,
    output olc_pkg::slot_t     slot,
    output logic               wave_valid_out,
    output olc_pkg::wave_t     wave_out
);
    import olc_pkg::*;

    logic             used_reg;
    logic             cur_reg;
    logic [KEY_W-1:0] key_reg;
    logic             wave_valid_reg;
    wave_t            wave_reg;
    slot_t            slot_next;
    wave_t            wave_next;

    assign slot           = '{used: used_reg, cur: cur_reg, key: key_reg};
    assign wave_valid_out = wave_valid_reg;
    assign wave_out       = wave_reg;

    always_comb
    begin
        slot_next         = slot;
        wave_next         = wave_in;
        wave_next.at_head = 1'b0;
        unique case (wave_in.act)
            ACT_APPEND:
            begin
                if (!used_reg && !wave_in.done)
                begin
                    slot_next.used = 1'b1;
                    slot_next.key  = wave_in.key;
                    slot_next.cur  = wave_in.at_head;
                    wave_next.done = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                // From the matching position onwards every entry moves one place
                // towards the head, taking its cursor mark along.
                if (wave_in.done || (used_reg && key_reg == wave_in.key))
                begin
                    if (!wave_in.done)
                    begin
                        wave_next.done    = 1'b1;
                        wave_next.del_cur = cur_reg;
                    end
                    slot_next = nb;
                end
            end
            ACT_FIRST:
            begin
                slot_next.cur = wave_in.at_head && used_reg;
            end
            ACT_NEXT:
            begin
                wave_next.move = 1'b0;
                if (wave_in.move)
                begin
                    slot_next.cur = 1'b1;
                end
                else if (cur_reg)
                begin
                    if (nb.used)
                    begin
                        slot_next.cur  = 1'b0;
                        wave_next.move = 1'b1;
                    end
                    else
                    begin
                        wave_next.blocked = 1'b1;
                    end
                end
            end
            ACT_PREV:
            begin
                wave_next.move = 1'b0;
                if (nb.cur)
                begin
                    slot_next.cur  = 1'b1;
                    wave_next.move = 1'b1;
                end
                else if (wave_in.move)
                begin
                    slot_next.cur = 1'b0;
                end
                else if (cur_reg)
                begin
                    // Only the head can hold the cursor with nobody taking it.
                    wave_next.blocked = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (slot_next.cur)
        begin
            wave_next.cap_valid = 1'b1;
            wave_next.cap_key   = slot_next.key;
        end
        if (wave_in.at_head)
        begin
            wave_next.head_used = slot_next.used;
            wave_next.head_key  = slot_next.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= 1'b0;
            cur_reg        <= 1'b0;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            wave_valid_reg <= wave_valid_in;
            if (wave_valid_in)
            begin
                used_reg <= slot_next.used;
                cur_reg  <= slot_next.cur;
            end
            else if (head_set && used_reg)
            begin
                cur_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_valid_in)
        begin
            key_reg <= slot_next.key;
        end
        wave_reg <= wave_next;
    end

endmodule

`default_nettype wire

/* rtl/ordered_list_with_cursor.sv */
// Top level: ordered key list with cursor, built as a row of list positions.
//
//  channel | signals                         | direction | handshake
//  --------+---------------------------------+-----------+-------------------
//  input   | action, song_number             | in        | in_valid/in_stall
//  result  | status, play, current_valid,    | out       | out_valid/out_stall
//          | current_number, entry_count     |           |
//
// Each beat sends an operation token along the row of CAPACITY positions, one
// position per cycle; the result is loaded into the output register, and a new
// beat is taken only once the previous result has been loaded there.
// Entries stay packed at the head end of the row in list order.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result waits in the output register while the next beat is taken.
`default_nettype none

module ordered_list_with_cursor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [olc_pkg::ACT_W-1:0]   action,
    input  wire logic [olc_pkg::KEY_W-1:0]   song_number,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [olc_pkg::STAT_W-1:0]       status,
    output logic                             play,
    output logic                             current_valid,
    output logic [olc_pkg::KEY_W-1:0]        current_number,
    output logic [olc_pkg::ENTRY_W-1:0]      entry_count
);
    import olc_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic                launch_valid_reg;
    wave_t               launch_reg;
    wave_t               launch_next;
    logic [ACT_W-1:0]    act_reg;
    logic [STAT_W-1:0]   pre_status_reg;
    wave_t               fin_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic                play_reg;
    logic                play_next;
    logic                cur_valid_reg;
    logic                cur_valid_next;
    logic [KEY_W-1:0]    cur_key_reg;
    logic [KEY_W-1:0]    cur_key_next;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic [STAT_W-1:0]   pre_status;
    logic [ACT_W-1:0]    eff_act;
    logic                head_set;
    logic [CAPACITY:0]   wave_valid;
    wave_t               waves [CAPACITY+1];
    slot_t               slots [CAPACITY];

    assign in_stall       = (state_reg != S_IDLE);
    assign accept         = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;
    assign load_out       = (state_reg == S_FIN) && out_free;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign play           = play_reg;
    assign current_valid  = cur_valid_reg;
    assign current_number = cur_key_reg;
    assign entry_count    = ENTRY_W'(count_reg);

    assign wave_valid[0] = launch_valid_reg;
    assign waves[0]      = launch_reg;
    // A deleted cursor entry hands the cursor to whatever is now at the head.
    assign head_set = (state_reg == S_RUN) && wave_valid[CAPACITY] && waves[CAPACITY].del_cur;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            slot_t nb_slot;
            logic  cell_head_set;
            if (i == CAPACITY - 1)
            begin : g_last
                assign nb_slot = '0;
            end
            else
            begin : g_mid
                assign nb_slot = slots[i+1];
            end
            if (i == 0)
            begin : g_head
                assign cell_head_set = head_set;
            end
            else
            begin : g_rest
                assign cell_head_set = 1'b0;
            end
            olc_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .wave_valid_in  (wave_valid[i]),
                .wave_in        (waves[i]),
                .nb             (nb_slot),
                .head_set       (cell_head_set),
                .slot           (slots[i]),
                .wave_valid_out (wave_valid[i+1]),
                .wave_out       (waves[i+1])
            );
        end
    endgenerate

    // Full and empty refusals are settled up front; the token then runs as a plain report.
    always_comb
    begin
        pre_status = ST_OK;
        unique case (action) inside
            ACT_APPEND:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    pre_status = ST_FULL;
                end
            end
            ACT_DELETE, ACT_FIRST, ACT_NEXT, ACT_PREV, ACT_PLAY, ACT_SHOW:
            begin
                if (count_reg == '0)
                begin
                    pre_status = ST_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
        eff_act = (pre_status != ST_OK) ? ACT_SHOW : action;

        launch_next         = '0;
        launch_next.act     = eff_act;
        launch_next.key     = song_number;
        launch_next.at_head = 1'b1;
    end

    always_comb
    begin
        status_next    = ST_OK;
        play_next      = 1'b0;
        count_next     = count_reg;
        cur_valid_next = 1'b0;
        cur_key_next   = '0;
        if (pre_status_reg != ST_OK)
        begin
            status_next = pre_status_reg;
        end
        else
        begin
            case (act_reg) inside
                ACT_APPEND:
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                ACT_DELETE:
                begin
                    if (fin_reg.done)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                ACT_FIRST, ACT_PLAY:
                begin
                    play_next = 1'b1;
                end
                ACT_NEXT, ACT_PREV:
                begin
                    if (fin_reg.blocked)
                    begin
                        status_next = ST_AT_END;
                    end
                    else
                    begin
                        play_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (fin_reg.cap_valid)
        begin
            cur_valid_next = 1'b1;
            cur_key_next   = fin_reg.cap_key;
        end
        else if (fin_reg.del_cur && fin_reg.head_used)
        begin
            cur_valid_next = 1'b1;
            cur_key_next   = fin_reg.head_key;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (wave_valid[CAPACITY])
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            launch_valid_reg <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            launch_valid_reg <= accept;
            if (load_out)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= action;
            pre_status_reg <= pre_status;
            launch_reg     <= launch_next;
        end
        if ((state_reg == S_RUN) && wave_valid[CAPACITY])
        begin
            fin_reg <= waves[CAPACITY];
        end
        if (load_out)
        begin
            status_reg    <= status_next;
            play_reg      <= play_next;
            cur_valid_reg <= cur_valid_next;
            cur_key_reg   <= cur_key_next;
        end
    end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the ordered list with cursor: directed and random actions checked beat by beat.
module tb_top;
    import olc_pkg::*;

    // Action code 7 has no meaning; the block must leave the list alone.
    localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = CAPACITY + 8;
    localparam int MAX_PRINTS  = 60;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic               play;
        logic               current_valid;
        logic [KEY_W-1:0]   current_number;
        logic [ENTRY_W-1:0] entry_count;
    } list_report_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   song_number;
    logic               out_valid;
    logic               out_stall;
    logic [STAT_W-1:0]  status;
    logic               play;
    logic               current_valid;
    logic [KEY_W-1:0]   current_number;
    logic [ENTRY_W-1:0] entry_count;

    // Model of the list: keys in list order and the cursor as a position, -1 for none.
    logic [KEY_W-1:0]   playlist[$];
    int                 cursor_pos;
    list_report_t       report_queue[$];
    list_report_t       awaited;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 mismatch_count;
    int                 results_seen;
    int                 quiet_cycles;

    ordered_list_with_cursor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .song_number    (song_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .play           (play),
        .current_valid  (current_valid),
        .current_number (current_number),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic list_report_t apply_action(input logic [ACT_W-1:0] act,
                                                  input logic [KEY_W-1:0] key);
        list_report_t rep;
        int hit;
        rep.status = ST_OK;
        rep.play   = 1'b0;
        hit        = -1;
        case (act)
            ACT_APPEND:
            begin
                if (playlist.size() >= CAPACITY)
                    rep.status = ST_FULL;
                else
                begin
                    playlist.push_back(key);
                    if (cursor_pos < 0)
                        cursor_pos = 0;
                end
            end
            ACT_DELETE:
            begin
                foreach (playlist[i])
                    if (hit < 0 && playlist[i] == key)
                        hit = i;
                if (playlist.size() == 0)
                    rep.status = ST_EMPTY;
                else if (hit < 0)
                    rep.status = ST_NOT_FOUND;
                else
                begin
                    playlist.delete(hit);
                    // Losing the cursor entry sends the cursor back to the head.
                    if (cursor_pos == hit)
                        cursor_pos = (playlist.size() > 0) ? 0 : -1;
                    else if (cursor_pos > hit)
                        cursor_pos--;
                end
            end
            ACT_FIRST:
            begin
                if (playlist.size() == 0)
                    rep.status = ST_EMPTY;
                else
                begin
                    cursor_pos = 0;
                    rep.play   = 1'b1;
                end
            end
            ACT_NEXT:
            begin
                if (cursor_pos < 0)
                    rep.status = ST_EMPTY;
                else if (cursor_pos == playlist.size() - 1)
                    rep.status = ST_AT_END;
                else
                begin
                    cursor_pos++;
                    rep.play = 1'b1;
                end
            end
            ACT_PREV:
            begin
                if (cursor_pos < 0)
                    rep.status = ST_EMPTY;
                else if (cursor_pos == 0)
                    rep.status = ST_AT_END;
                else
                begin
                    cursor_pos--;
                    rep.play = 1'b1;
                end
            end
            ACT_PLAY:
            begin
                if (cursor_pos < 0)
                    rep.status = ST_EMPTY;
                else
                    rep.play = 1'b1;
            end
            ACT_SHOW:
            begin
                if (cursor_pos < 0)
                    rep.status = ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        rep.current_valid  = (cursor_pos >= 0);
        rep.current_number = (cursor_pos >= 0) ? playlist[cursor_pos] : '0;
        rep.entry_count    = ENTRY_W'(playlist.size());
        return rep;
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("tb_top: result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    // Valid is left high after acceptance; whoever comes next lowers or reuses it.
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        song_number <= key;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        report_queue.push_back(apply_action(act, key));
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (report_queue.size() != 0);
    endtask

    task automatic test_directed;
        // Every action but append on an empty list, the spare code among them.
        send_beat(ACT_DELETE, 16'hFFFF);
        send_beat(ACT_FIRST, 16'h0000);
        send_beat(ACT_NEXT, 16'hFFFF);
        send_beat(ACT_PREV, 16'h0000);
        send_beat(ACT_PLAY, 16'hFFFF);
        send_beat(ACT_SHOW, 16'h0000);
        send_beat(ACT_SPARE, 16'h5A5A);
        // The first append also takes the cursor; duplicates are kept.
        send_beat(ACT_APPEND, 16'h0000);
        send_beat(ACT_APPEND, 16'hFFFF);
        send_beat(ACT_APPEND, 16'h8000);
        send_beat(ACT_APPEND, 16'hFFFF);
        send_beat(ACT_SHOW, 16'hA5A5);
        repeat (4) send_beat(ACT_NEXT, 16'h0001);
        send_beat(ACT_PREV, 16'h7FFF);
        send_beat(ACT_PLAY, 16'h0000);
        send_beat(ACT_FIRST, 16'h0000);
        send_beat(ACT_PREV, 16'h0000);
        send_beat(ACT_DELETE, 16'h1234);
        // Removing the cursor entry at the head, then one in the middle.
        send_beat(ACT_DELETE, 16'h0000);
        send_beat(ACT_NEXT, 16'h0000);
        send_beat(ACT_DELETE, 16'h8000);
        send_beat(ACT_DELETE, 16'hFFFF);
        send_beat(ACT_SPARE, 16'hFFFF);
    endtask

    task automatic test_capacity;
        int free_entries;
        free_entries = CAPACITY - playlist.size();
        // Fill the list and push a few appends past the limit.
        repeat (free_entries + 3) send_beat(ACT_APPEND, KEY_W'($urandom));
        wait_for_results();
        send_beat(ACT_FIRST, KEY_W'($urandom));
        send_beat(ACT_PREV, KEY_W'($urandom));
        repeat (CAPACITY + 1) send_beat(ACT_NEXT, KEY_W'($urandom));
        send_beat(ACT_DELETE, playlist[cursor_pos]);
        while (playlist.size() > 0)
        begin
            if ($urandom_range(9) == 0)
                send_beat(ACT_DELETE, KEY_W'($urandom));
            else
                send_beat(ACT_DELETE, playlist[$urandom_range(playlist.size() - 1)]);
        end
        send_beat(ACT_SHOW, KEY_W'($urandom));
    endtask

    task automatic test_random_mix(input int count);
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        int pick;
        int grow;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_for_results();
            // Appends thin out once the list is well filled so that it keeps moving.
            grow = (playlist.size() > 40) ? 20 : 40;
            pick = $urandom_range(99);
            if ($urandom_range(1))
                key = KEY_W'($urandom);
            else
                key = KEY_W'($urandom_range(7));
            if (pick < 3)
                act = ACT_SPARE;
            else if (pick < grow)
                act = ACT_APPEND;
            else if (pick < grow + 22)
            begin
                act = ACT_DELETE;
                if (playlist.size() > 0 && $urandom_range(99) < 80)
                    key = playlist[$urandom_range(playlist.size() - 1)];
            end
            else
            begin
                case ($urandom_range(9))
                    0:       act = ACT_FIRST;
                    1, 2, 3: act = ACT_NEXT;
                    4, 5, 6: act = ACT_PREV;
                    7:       act = ACT_PLAY;
                    default: act = ACT_SHOW;
                endcase
            end
            send_beat(act, key);
        end
    endtask

    task automatic finish_run;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_queue.size() == 0)
                note_mismatch("result beat with nothing awaited");
            else
            begin
                awaited = report_queue.pop_front();
                if (status !== awaited.status)
                    note_mismatch($sformatf("status got %0d, expected %0d",
                                            status, awaited.status));
                if (play !== awaited.play)
                    note_mismatch($sformatf("play got %0d, expected %0d",
                                            play, awaited.play));
                if (current_valid !== awaited.current_valid)
                    note_mismatch($sformatf("current_valid got %0d, expected %0d",
                                            current_valid, awaited.current_valid));
                if (current_number !== awaited.current_number)
                    note_mismatch($sformatf("current_number got %h, expected %h",
                                            current_number, awaited.current_number));
                if (entry_count !== awaited.entry_count)
                    note_mismatch($sformatf("entry_count got %0d, expected %0d",
                                            entry_count, awaited.entry_count));
            end
            results_seen++;
        end
    end

    // Any beat on either channel shows the block is still alive.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_SHOW;
        song_number    = '0;
        cursor_pos     = -1;
        send_idle_pct  = 19;
        recv_stall_pct = 64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random_mix(130);
        send_idle_pct  = 64;
        recv_stall_pct = 19;
        test_random_mix(130);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(130);
        finish_run();
    end

endmodule
